### hw/rtl/v3n_pkg.sv
// ----------------------------------------------------------------------------
// v3n_pkg: shared types and constants for the vector normalize core
// Widths of the component, length and quotient paths, and the beat that
// travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package v3n_pkg;

    localparam int COMP_BITS  = 16;
    localparam int FRAC_BITS  = 14;
    localparam int LEN_BITS   = 16;
    localparam int SUM_BITS   = 32;
    localparam int QUO_BITS   = FRAC_BITS + 1;
    localparam int QDEPTH     = 4;
    localparam int QAW        = 2;

    localparam logic [QUO_BITS-1:0] UNIT_ONE = QUO_BITS'(1) << FRAC_BITS;

    // One vector after the front end: magnitudes, signs, sum of squares
    typedef struct packed {
        logic [2:0][COMP_BITS-1:0] mag;
        logic [2:0]                neg;
        logic [SUM_BITS-1:0]       sum;
    } t_item;

    // Queue status seen by the top level
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

### hw/rtl/v3n_front.sv
// ----------------------------------------------------------------------------
// v3n_front: accept and classify
// Take absolute values and signs, square each component, then sum.
// ----------------------------------------------------------------------------
module v3n_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [v3n_pkg::COMP_BITS-1:0] i_x,
    input  logic [v3n_pkg::COMP_BITS-1:0] i_y,
    input  logic [v3n_pkg::COMP_BITS-1:0] i_z,
    output logic                          o_valid,
    output v3n_pkg::t_item                o_item
);
    logic [2:0][v3n_pkg::COMP_BITS-1:0] n_mag;
    logic [2:0]                         n_neg;
    logic [2:0][v3n_pkg::COMP_BITS-1:0] raw;

    logic                                r_v1;
    logic [2:0][v3n_pkg::COMP_BITS-1:0]  r_mag1;
    logic [2:0]                          r_neg1;
    logic [2:0][v3n_pkg::SUM_BITS-1:0]   r_sq1;
    logic                                r_v2;
    v3n_pkg::t_item                      r_item2;

    assign raw = {i_z, i_y, i_x};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = raw[k][v3n_pkg::COMP_BITS-1];
            n_mag[k] = n_neg[k] ? (~raw[k] + v3n_pkg::COMP_BITS'(1)) : raw[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_mag1 <= n_mag;
        r_neg1 <= n_neg;
        for (int k = 0; k < 3; k++) begin
            r_sq1[k] <= v3n_pkg::SUM_BITS'(n_mag[k]) * v3n_pkg::SUM_BITS'(n_mag[k]);
        end
        r_item2.mag <= r_mag1;
        r_item2.neg <= r_neg1;
        r_item2.sum <= r_sq1[0] + r_sq1[1] + r_sq1[2];
    end

    assign o_valid = r_v2;
    assign o_item  = r_item2;
endmodule

### hw/rtl/v3n_queue.sv
// ----------------------------------------------------------------------------
// v3n_queue: short queue between front and back end
// Register-based FIFO; pop when not empty.
// ----------------------------------------------------------------------------
module v3n_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  v3n_pkg::t_item  i_item,
    input  logic            i_pop,
    output v3n_pkg::t_item  o_item,
    output v3n_pkg::t_qstat o_stat
);
    v3n_pkg::t_item          r_mem [v3n_pkg::QDEPTH];
    logic [v3n_pkg::QAW-1:0] r_wr;
    logic [v3n_pkg::QAW-1:0] r_rd;
    logic [v3n_pkg::QAW:0]   r_cnt;
    logic                    do_pop;
    logic                    do_push;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == (v3n_pkg::QAW+1)'(v3n_pkg::QDEPTH));
    assign do_pop  = i_pop && !o_stat.empty;
    assign do_push = i_push && !o_stat.full;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (v3n_pkg::QAW+1)'(do_push) - (v3n_pkg::QAW+1)'(do_pop);
        end
        if (do_push) r_mem[r_wr] <= i_item;
    end
endmodule

### hw/rtl/v3n_back.sv
// ----------------------------------------------------------------------------
// v3n_back: root and scale pipeline
// One root bit per stage, then one quotient bit per stage in three lanes.
// ----------------------------------------------------------------------------
module v3n_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  v3n_pkg::t_item               i_item,
    input  logic [v3n_pkg::LEN_BITS-1:0] i_min_mag,
    output logic                         o_valid,
    output logic [2:0][v3n_pkg::COMP_BITS-1:0] o_unit,
    output logic [v3n_pkg::LEN_BITS-1:0] o_length,
    output logic                         o_too_small
);
    localparam int NS  = v3n_pkg::LEN_BITS;
    localparam int ND  = v3n_pkg::QUO_BITS;
    localparam int RW  = 2 * v3n_pkg::LEN_BITS + 2;
    localparam int DW  = v3n_pkg::COMP_BITS + v3n_pkg::FRAC_BITS + 1;

    // root stages
    logic                         r_sv   [NS+1];
    logic [RW-1:0]                r_srem [NS+1];
    logic [v3n_pkg::LEN_BITS-1:0] r_sroot[NS+1];
    logic [2:0][v3n_pkg::COMP_BITS-1:0] r_smag [NS+1];
    logic [2:0]                   r_sneg [NS+1];

    // divide stages
    logic                         r_dv   [1:ND];
    logic [2:0][DW-1:0]           r_drem [1:ND];
    logic [2:0][ND-1:0]           r_dq   [1:ND];
    logic [v3n_pkg::LEN_BITS-1:0] r_dlen [1:ND];
    logic [2:0]                   r_dneg [1:ND];

    logic                         r_ov;
    logic [2:0][v3n_pkg::COMP_BITS-1:0] r_unit;
    logic [v3n_pkg::LEN_BITS-1:0] r_len;
    logic                         r_small;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv[0] <= 1'b0;
        else          r_sv[0] <= i_valid;
        r_srem[0]  <= RW'(i_item.sum);
        r_sroot[0] <= '0;
        r_smag[0]  <= i_item.mag;
        r_sneg[0]  <= i_item.neg;
    end

    for (genvar s = 0; s < NS; s++) begin : g_root
        localparam int B = NS - 1 - s;
        logic [RW-1:0] term;
        assign term = (RW'(r_sroot[s]) << (B + 1)) + (RW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_sv[s+1] <= 1'b0;
            else          r_sv[s+1] <= r_sv[s];
            if (r_srem[s] >= term) begin
                r_srem[s+1]  <= r_srem[s] - term;
                r_sroot[s+1] <= r_sroot[s] | (v3n_pkg::LEN_BITS'(1) << B);
            end else begin
                r_srem[s+1]  <= r_srem[s];
                r_sroot[s+1] <= r_sroot[s];
            end
            r_smag[s+1] <= r_smag[s];
            r_sneg[s+1] <= r_sneg[s];
        end
    end

    for (genvar s = 0; s < ND; s++) begin : g_div
        localparam int B = ND - 1 - s;
        logic                         v_in;
        logic [2:0][DW-1:0]           rem_in;
        logic [2:0][ND-1:0]           q_in;
        logic [v3n_pkg::LEN_BITS-1:0] len_in;
        logic [2:0]                   neg_in;
        logic [DW-1:0]                dvs;

        // first stage loads the scaled magnitudes straight from the root
        if (s == 0) begin : g_load
            assign v_in   = r_sv[NS];
            assign len_in = r_sroot[NS];
            assign neg_in = r_sneg[NS];
            assign q_in   = '0;
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign rem_in[k] = DW'(r_smag[NS][k]) << v3n_pkg::FRAC_BITS;
            end
        end else begin : g_pass
            assign v_in   = r_dv[s];
            assign len_in = r_dlen[s];
            assign neg_in = r_dneg[s];
            assign q_in   = r_dq[s];
            assign rem_in = r_drem[s];
        end

        assign dvs = DW'(len_in) << B;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_dv[s+1] <= 1'b0;
            else          r_dv[s+1] <= v_in;
            for (int k = 0; k < 3; k++) begin
                if (rem_in[k] >= dvs) begin
                    r_drem[s+1][k] <= rem_in[k] - dvs;
                    r_dq[s+1][k]   <= q_in[k] | (ND'(1) << B);
                end else begin
                    r_drem[s+1][k] <= rem_in[k];
                    r_dq[s+1][k]   <= q_in[k];
                end
            end
            r_dlen[s+1] <= len_in;
            r_dneg[s+1] <= neg_in;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [ND-1:0] q;
        logic          is_short;
        if (!i_rst_n) r_ov <= 1'b0;
        else          r_ov <= r_dv[ND];
        is_short = (r_dlen[ND] <= i_min_mag);
        for (int k = 0; k < 3; k++) begin
            q = (r_dq[ND][k] > v3n_pkg::UNIT_ONE) ? v3n_pkg::UNIT_ONE : r_dq[ND][k];
            if (is_short)
                r_unit[k] <= '0;
            else if (r_dneg[ND][k])
                r_unit[k] <= ~v3n_pkg::COMP_BITS'(q) + v3n_pkg::COMP_BITS'(1);
            else
                r_unit[k] <= v3n_pkg::COMP_BITS'(q);
        end
        r_len   <= r_dlen[ND];
        r_small <= is_short;
    end

    assign o_valid     = r_ov;
    assign o_unit      = r_unit;
    assign o_length    = r_len;
    assign o_too_small = r_small;
endmodule

### hw/rtl/vector3_normalize_core.sv
// ----------------------------------------------------------------------------
// vector3_normalize_core: 3D vector normalization to Q1.14
// Length by floor square root, unit vector by pipelined long division.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive i_comp_x/y/z and raise i_start; the beat is taken at a
//   rising edge with i_start high and o_busy low.
//   Result beat: o_valid pulses for one cycle with o_unit_x/y/z, o_length and
//   o_too_small. The receiver cannot stall, and nothing here needs it to.
//   Path: an accepted beat passes through the front registers (abs/square,
//   sum), the queue, the back-end input register, 16 root stages (one root
//   bit each), 15 divide stages (one quotient bit each) and the output
//   register, which drives o_valid.
//   Throughput: one vector per cycle; every stage is fully pipelined, so the
//   queue drains each cycle and o_busy stays low in practice.
//   Configuration: APB register 0 (byte address 0) is min_magnitude; a
//   length at or below it yields a zero vector with o_too_small set.
//   Write it only while no vector is in flight.
//   Reset: synchronous, active low; clears all valid flags, the queue and
//   min_magnitude. In-flight vectors are dropped.
// ----------------------------------------------------------------------------
module vector3_normalize_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [15:0] i_comp_x,
    input  logic [15:0] i_comp_y,
    input  logic [15:0] i_comp_z,
    output logic        o_valid,
    output logic [15:0] o_unit_x,
    output logic [15:0] o_unit_y,
    output logic [15:0] o_unit_z,
    output logic [15:0] o_length,
    output logic        o_too_small,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic                   accept;
    logic                   f_valid;
    v3n_pkg::t_item         f_item;
    v3n_pkg::t_item         q_item;
    v3n_pkg::t_qstat        q_stat;
    logic [2:0][15:0]       unit;
    logic [15:0]            r_min_mag;

    // APB: single register, zero wait states
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_min_mag} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_mag <= '0;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_min_mag <= pwdata[15:0];
        end
    end

    // Hold off new beats only if the queue fills
    assign o_busy = q_stat.full;
    assign accept = i_start && !o_busy;

    v3n_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_x     (i_comp_x),
        .i_y     (i_comp_y),
        .i_z     (i_comp_z),
        .o_valid (f_valid),
        .o_item  (f_item)
    );

    // Advance the queue head into the back end every cycle it holds a beat
    v3n_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_item  (f_item),
        .i_pop   (!q_stat.empty),
        .o_item  (q_item),
        .o_stat  (q_stat)
    );

    v3n_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (!q_stat.empty),
        .i_item      (q_item),
        .i_min_mag   (r_min_mag),
        .o_valid     (o_valid),
        .o_unit      (unit),
        .o_length    (o_length),
        .o_too_small (o_too_small)
    );

    assign o_unit_x = unit[0];
    assign o_unit_y = unit[1];
    assign o_unit_z = unit[2];

`ifndef NO_ASSERTIONS
    a_zero_when_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_small |-> o_unit_x == 16'd0 && o_unit_y == 16'd0
                                   && o_unit_z == 16'd0)
        else $error("nonzero unit vector on short length");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_unit_x) <= 16384 && $signed(o_unit_x) >= -16384)
                 && ($signed(o_unit_y) <= 16384 && $signed(o_unit_y) >= -16384)
                 && ($signed(o_unit_z) <= 16384 && $signed(o_unit_z) >= -16384))
        else $error("unit component out of range");

    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_stat.full)
        else $error("queue filled although back end never stalls");
`endif
endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the vector normalize core
// Streams signed 3D vectors into the core, predicts the length, the Q1.14
// unit vector and the too-small flag for each, and checks every result beat
// in order. min_magnitude is rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_vec;

    typedef struct packed {
        logic [15:0] ux;
        logic [15:0] uy;
        logic [15:0] uz;
        logic [15:0] len;
        logic        short_flag;
    } t_norm;

    localparam logic [2:0] REG_MIN_MAG = 3'd0;
    localparam int         DRAIN_CYCLES = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [15:0] i_comp_x = '0;
    logic [15:0] i_comp_y = '0;
    logic [15:0] i_comp_z = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_busy, o_valid, o_too_small, pready;
    logic [15:0] o_unit_x, o_unit_y, o_unit_z, o_length;
    logic [31:0] prdata;

    vector3_normalize_core dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: the bench's own copy of the threshold
    logic [15:0] min_mag_shadow = '0;

    t_vec  vec_pending[$];
    t_norm norm_expected[$];
    int    errors = 0;
    int    beats_seen = 0;
    int    small_seen = 0;
    bit    gaps_on = 1'b1;

    function automatic logic [15:0] isqrt32(input logic [33:0] n);
        logic [33:0] res, bitv, rem;
        res = '0; rem = n; bitv = 34'h1 << 32;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res[15:0];
    endfunction

    function automatic logic [15:0] unit_comp(input logic [15:0] c, input logic [15:0] len);
        logic [16:0] mag;
        logic [31:0] q;
        mag = c[15] ? 17'(-$signed({c[15], c})) : {1'b0, c};
        q = ({15'd0, mag} << 14) / len;
        if (q > 32'd16384) q = 32'd16384;
        if (c[15]) q = -q;
        return q[15:0];
    endfunction

    function automatic t_norm normalize(input t_vec v);
        t_norm r;
        logic [33:0] sum;
        sum = 34'($signed(v.x)) * 34'($signed(v.x)) + 34'($signed(v.y)) * 34'($signed(v.y))
            + 34'($signed(v.z)) * 34'($signed(v.z));
        r.len = isqrt32(sum);
        if (r.len > min_mag_shadow) begin
            r.ux = unit_comp(v.x, r.len);
            r.uy = unit_comp(v.y, r.len);
            r.uz = unit_comp(v.z, r.len);
            r.short_flag = 1'b0;
        end else begin
            r.ux = '0; r.uy = '0; r.uz = '0;
            r.short_flag = 1'b1;
        end
        return r;
    endfunction

    // Driver: pop a vector, hold it until accepted, insert random gaps
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                norm_expected.push_back(normalize({i_comp_x, i_comp_y, i_comp_z}));
            end
            if (!(i_start && o_busy)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_start <= 1'b0;
                end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                    gap_left <= $urandom_range(1, 17) - 1;
                    i_start <= 1'b0;
                end else if (vec_pending.size() > 0) begin
                    {i_comp_x, i_comp_y, i_comp_z} <= vec_pending.pop_front();
                    i_start <= 1'b1;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_norm exp_n;
        if (i_rst_n && o_valid) begin
            beats_seen++;
            if (norm_expected.size() == 0) begin
                $display("%0t: unexpected result beat len=%0d", $realtime, o_length);
                errors++;
            end else begin
                exp_n = norm_expected.pop_front();
                if (exp_n.short_flag) small_seen++;
                if (o_unit_x !== exp_n.ux)
                    $display("%0t: unit_x exp %0d got %0d", $realtime,
                             $signed(exp_n.ux), $signed(o_unit_x));
                if (o_unit_y !== exp_n.uy)
                    $display("%0t: unit_y exp %0d got %0d", $realtime,
                             $signed(exp_n.uy), $signed(o_unit_y));
                if (o_unit_z !== exp_n.uz)
                    $display("%0t: unit_z exp %0d got %0d", $realtime,
                             $signed(exp_n.uz), $signed(o_unit_z));
                if (o_length !== exp_n.len)
                    $display("%0t: length exp %0d got %0d", $realtime, exp_n.len, o_length);
                if (o_too_small !== exp_n.short_flag)
                    $display("%0t: too_small exp %0b got %0b", $realtime,
                             exp_n.short_flag, o_too_small);
                if ({o_unit_x, o_unit_y, o_unit_z, o_length, o_too_small} !== exp_n)
                    errors++;
            end
        end
    end

    task automatic wait_idle();
        while (vec_pending.size() > 0 || i_start || norm_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle
    task automatic write_min_mag(input logic [15:0] value);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= REG_MIN_MAG; pwdata <= {16'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        min_mag_shadow = value;
    endtask

    function automatic logic [15:0] rand_comp(input int scale);
        case (scale)
            0: return 16'($signed($urandom_range(0, 16)) - 8);
            1: return 16'($signed($urandom_range(0, 1000)) - 500);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int n);
        int sc;
        repeat (n) begin
            sc = $urandom_range(0, 2);
            vec_pending.push_back({rand_comp(sc), rand_comp(sc), rand_comp(sc)});
        end
    endtask

    initial begin
        logic [15:0] thresholds[5];
        thresholds = '{16'd0, 16'd65535, 16'd7, 16'd300, 16'd20000};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero vector, axis extremes, -32768 corner, saturation edges
        vec_pending.push_back({16'd0, 16'd0, 16'd0});
        vec_pending.push_back({16'h7fff, 16'd0, 16'd0});
        vec_pending.push_back({16'h8000, 16'd0, 16'd0});
        vec_pending.push_back({16'd0, 16'h8000, 16'd0});
        vec_pending.push_back({16'd0, 16'd0, 16'h8000});
        vec_pending.push_back({16'h8000, 16'h8000, 16'h8000});
        vec_pending.push_back({16'h7fff, 16'h7fff, 16'h7fff});
        vec_pending.push_back({16'h7fff, 16'h8000, 16'h7fff});
        vec_pending.push_back({16'd1, 16'd0, 16'd0});
        vec_pending.push_back({16'hffff, 16'hffff, 16'hffff});
        vec_pending.push_back({16'd3, 16'd4, 16'd0});
        vec_pending.push_back({16'd1, 16'd1, 16'd1});
        vec_pending.push_back({16'h5555, 16'haaaa, 16'h00ff});
        wait_idle();

        // Threshold at the floor length 5 of all three vectors, just below the true length of two
        write_min_mag(16'd5);
        vec_pending.push_back({16'd3, 16'd4, 16'd0});
        vec_pending.push_back({16'd3, 16'd4, 16'd1});
        vec_pending.push_back({16'hfffd, 16'hfffc, 16'd1});
        wait_idle();

        // Random phases across thresholds; hold the sender until drained each time
        foreach (thresholds[i]) begin
            write_min_mag(thresholds[i]);
            queue_random(140);
            wait_idle();
        end

        // Final stretch: no gaps, back-to-back beats
        write_min_mag(16'd0);
        gaps_on = 1'b0;
        queue_random(100);
        wait_idle();

        $display("covered %0d result beats, %0d flagged too small, 7 threshold settings",
                 beats_seen, small_seen);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
